>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/gemc_pkg.sv
`default_nettype none
package gemc_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 32;
  localparam int unsigned VC_W             = 5;
  localparam logic [VC_W-1:0] VC_RESET     = 5'd12;
  localparam int unsigned CHAR_W           = 8;
  localparam logic [CHAR_W-1:0] HDR_OFFSET = 8'd63;
  localparam int unsigned BITS_PER_CHAR    = 6;
  localparam int unsigned CUT_W            = 9;
  localparam int unsigned REC_W            = 10;
  localparam int unsigned CNT_W            = 32;
  // Step counter of the Gray-code walk: bit n-1 marks the end of the walk
  localparam int unsigned STEP_W           = 2 ** VC_W;
  localparam int unsigned DELTA_W          = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_EV_INIT,
    ST_EVAL,
    ST_FINISH,
    ST_ERROR
  } gemc_state_t;

  typedef enum logic {
    STATUS_OK       = 1'b0,
    STATUS_MISMATCH = 1'b1
  } gemc_status_t;

  typedef struct packed {
    logic init;
    logic run;
  } gemc_ctrl_t;

  typedef struct packed {
    logic steps_done;
    logic pending;
  } gemc_stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/gemc_if.sv
`default_nettype none
interface gemc_in_if import gemc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              starts_graph;

  modport source (output valid, output char_code, output starts_graph, input ready);
  modport sink   (input valid, input char_code, input starts_graph, output ready);
endinterface

interface gemc_out_if import gemc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    status;
  logic [CUT_W-1:0]        edge_count;
  logic [CUT_W-1:0]        max_cut;
  logic [CUT_W-1:0]        deficiency;
  logic                    new_record;
  logic signed [REC_W-1:0] record_deficiency;
  logic [CNT_W-1:0]        record_ties;
  logic [CNT_W-1:0]        graphs_seen;

  modport source (output valid, output status, output edge_count, output max_cut,
                  output deficiency, output new_record, output record_deficiency,
                  output record_ties, output graphs_seen, input ready);
  modport sink   (input valid, input status, input edge_count, input max_cut,
                  input deficiency, input new_record, input record_deficiency,
                  input record_ties, input graphs_seen, output ready);
endinterface

interface gemc_cfg_if import gemc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [VC_W-1:0] vertex_count;

  modport source (output valid, output vertex_count, input ready);
  modport sink   (input valid, input vertex_count, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/gemc_cut_unit.sv
`default_nettype none
module gemc_cut_unit import gemc_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  gemc_ctrl_t              ctrl,
  input  logic [VC_W-1:0]         vertex_count,
  input  logic [MAX_VERTICES-1:0] rows [MAX_VERTICES],
  input  logic [VC_W-1:0]         degrees [MAX_VERTICES],
  output gemc_stat_t              stat,
  output logic [CUT_W-1:0]        peak_cut
);

  localparam int unsigned VW = $clog2(MAX_VERTICES);

  logic [STEP_W-1:0]        k;
  logic [MAX_VERTICES-1:0]  side;
  logic signed [DELTA_W-1:0] delta;
  logic                     pend;
  logic [CUT_W-1:0]         cur;
  logic [CUT_W-1:0]         best;

  logic [VC_W-1:0]          last_idx;
  logic                     done;
  logic [VC_W-1:0]          tz;
  logic [VC_W-1:0]          v;
  logic                     v_ok;
  logic [VW-1:0]            vi;
  logic [MAX_VERTICES-1:0]  row_sel;
  logic [VC_W-1:0]          deg_sel;
  logic                     side_bit;
  logic [VC_W:0]            ones;
  logic signed [DELTA_W-1:0] two_a;
  logic signed [DELTA_W-1:0] deg_s;
  logic signed [DELTA_W-1:0] delta_next;
  logic [CUT_W-1:0]         cur_next;

  assign last_idx = vertex_count - VC_W'(1);
  assign done     = k[last_idx];

  // lowest set bit of the step number picks the vertex to flip
  always_comb begin
    tz = '0;
    for (int i = STEP_W - 1; i >= 0; i--) begin
      if (k[i]) begin
        tz = VC_W'(i);
      end
    end
  end

  assign v        = tz + VC_W'(1);
  assign v_ok     = ({1'b0, v} < (VC_W + 1)'(MAX_VERTICES));
  assign vi       = v[VW-1:0];
  assign row_sel  = v_ok ? rows[vi] : '0;
  assign deg_sel  = v_ok ? degrees[vi] : '0;
  assign side_bit = v_ok ? side[vi] : 1'b0;

  // neighbors of v already on vertex 0's side
  always_comb begin
    logic [MAX_VERTICES-1:0] masked;
    masked = row_sel & side;
    ones   = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      ones = ones + (VC_W + 1)'(masked[i]);
    end
  end

  assign two_a      = $signed({1'b0, ones, 1'b0});
  assign deg_s      = $signed({3'b000, deg_sel});
  assign delta_next = side_bit ? (two_a - deg_s) : (deg_s - two_a);
  assign cur_next   = cur + {delta[DELTA_W-1], delta};

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      k    <= STEP_W'(1);
      side <= MAX_VERTICES'(1);
      cur  <= '0;
      best <= '0;
    end else if (ctrl.init) begin
      pend <= 1'b0;
      k    <= STEP_W'(1);
      side <= MAX_VERTICES'(1);
      cur  <= {{(CUT_W - VC_W){1'b0}}, degrees[0]};
      best <= {{(CUT_W - VC_W){1'b0}}, degrees[0]};
    end else begin
      if (ctrl.run && !done) begin
        k     <= k + STEP_W'(1);
        delta <= delta_next;
        pend  <= 1'b1;
        if (v_ok) begin
          side[vi] <= ~side[vi];
        end
      end else begin
        pend <= 1'b0;
      end
      if (pend) begin
        cur <= cur_next;
        if (cur_next > best) begin
          best <= cur_next;
        end
      end
    end
  end

  assign stat.steps_done = done;
  assign stat.pending    = pend;
  assign peak_cut        = best;

endmodule
`default_nettype wire

>>> hw/rtl/graph_exhaustive_max_cut_top.sv
// Flow: header and data characters are accepted in the idle state; each data character is then
//   unpacked bit by bit in the decode state; after the last bit, evaluation runs the init and eval states.
// Graphs are handled one at a time: no character is accepted while a graph is decoded or
//   evaluated, and the single cut-step unit does one Gray-code step per cycle.
// Reset: synchronous; vertex_count = 12, record = -1, counters zero, no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module graph_exhaustive_max_cut_top import gemc_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  gemc_in_if.sink   char_in,
  gemc_out_if.source result_out,
  gemc_cfg_if.sink  cfg
);

  localparam int unsigned VW = $clog2(MAX_VERTICES);

  gemc_state_t state, state_next;
  gemc_ctrl_t  ctrl;
  gemc_stat_t  stat;

  // configuration
  logic [VC_W-1:0] vcount;

  // graph under construction
  logic [MAX_VERTICES-1:0] adj [MAX_VERTICES];
  logic [VC_W-1:0]         deg [MAX_VERTICES];
  logic [CUT_W-1:0]        edges;
  logic [VC_W-1:0]         row_pos;
  logic [VC_W-1:0]         col_pos;
  logic                    graph_open;
  logic [BITS_PER_CHAR-1:0] six;
  logic [2:0]              data_idx;

  // running record
  logic signed [REC_W-1:0] record;
  logic [CNT_W-1:0]        ties;
  logic [CNT_W-1:0]        graphs;

  // output register
  logic                    out_valid;
  logic                    out_status;
  logic [CUT_W-1:0]        out_edges;
  logic [CUT_W-1:0]        out_cut;
  logic [CUT_W-1:0]        out_def;
  logic                    out_newrec;
  logic signed [REC_W-1:0] out_record;
  logic [CNT_W-1:0]        out_ties;
  logic [CNT_W-1:0]        out_graphs;

  logic [CUT_W-1:0] peak_cut;
  logic             in_acc;
  logic             out_free;
  logic             out_load;
  logic             hdr_ok;

  logic             data_bit;
  logic             i_ok;
  logic             j_ok;
  logic             set_edge;
  logic [VW-1:0]    ii;
  logic [VW-1:0]    jj;
  logic [VC_W-1:0]  row_inc;
  logic             wrap;
  logic [VC_W-1:0]  row_n;
  logic [VC_W-1:0]  col_n;
  logic             graph_full;

  logic signed [REC_W-1:0] bip;
  logic                    new_rec;
  logic [CNT_W-1:0]        ties_next;
  logic [CNT_W-1:0]        graphs_next;
  logic signed [REC_W-1:0] record_next;

  // shared Gray-code cut stepper
  gemc_cut_unit #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_cut (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .vertex_count (vcount),
    .rows         (adj),
    .degrees      (deg),
    .stat         (stat),
    .peak_cut     (peak_cut)
  );

  assign char_in.ready = (state == ST_IDLE);
  assign cfg.ready     = 1'b1;
  assign in_acc        = char_in.valid && char_in.ready;
  assign out_free      = !out_valid || result_out.ready;
  // a result transaction is loaded from the finish or error state
  assign out_load      = ((state == ST_FINISH) || (state == ST_ERROR)) && out_free;

  // header must carry exactly the configured count, within the array size
  assign hdr_ok = (vcount != '0)
               && ({1'b0, vcount} <= (VC_W + 1)'(MAX_VERTICES))
               && (char_in.char_code == (CHAR_W'(vcount) + HDR_OFFSET));

  // one triangle bit per cycle in the decode state, most significant first
  assign data_bit   = six[BITS_PER_CHAR-1];
  assign i_ok       = ({1'b0, row_pos} < (VC_W + 1)'(MAX_VERTICES));
  assign j_ok       = ({1'b0, col_pos} < (VC_W + 1)'(MAX_VERTICES));
  assign set_edge   = data_bit && i_ok && j_ok;
  assign ii         = row_pos[VW-1:0];
  assign jj         = col_pos[VW-1:0];
  assign row_inc    = row_pos + VC_W'(1);
  assign wrap       = (row_inc >= col_pos);
  assign row_n      = wrap ? '0 : row_inc;
  assign col_n      = wrap ? (col_pos + VC_W'(1)) : col_pos;
  assign graph_full = (col_n >= vcount);

  // record bookkeeping at the end of an evaluation
  assign bip         = $signed({1'b0, edges}) - $signed({1'b0, peak_cut});
  assign new_rec     = (bip > record);
  assign record_next = new_rec ? bip : record;
  assign graphs_next = (graphs != '1) ? (graphs + CNT_W'(1)) : graphs;

  always_comb begin
    ties_next = ties;
    if (new_rec) begin
      ties_next = CNT_W'(1);
    end else if ((bip == record) && (ties != '1)) begin
      ties_next = ties + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (char_in.starts_graph) begin
            if (!hdr_ok) begin
              state_next = ST_ERROR;
            end else if (vcount == VC_W'(1)) begin
              // a single vertex has no triangle bits: evaluate at once
              state_next = ST_EV_INIT;
            end
          end else if (graph_open) begin
            state_next = ST_DECODE;
          end
        end
      end
      ST_DECODE: begin
        if (graph_full) begin
          state_next = ST_EV_INIT;
        end else if (data_idx == 3'(BITS_PER_CHAR - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_EV_INIT: begin
        ctrl.init  = 1'b1;
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        ctrl.run = 1'b1;
        if (stat.steps_done && !stat.pending) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_ERROR: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount     <= VC_RESET;
      graph_open <= 1'b0;
      edges      <= '0;
      row_pos    <= '0;
      col_pos    <= VC_W'(1);
      record     <= '1;
      ties       <= '0;
      graphs     <= '0;
      out_valid  <= 1'b0;
      for (int r = 0; r < MAX_VERTICES; r++) begin
        adj[r] <= '0;
        deg[r] <= '0;
      end
    end else begin
      if (cfg.valid && cfg.ready) begin
        vcount <= cfg.vertex_count;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (char_in.starts_graph) begin
              if (hdr_ok) begin
                for (int r = 0; r < MAX_VERTICES; r++) begin
                  adj[r] <= '0;
                  deg[r] <= '0;
                end
                edges      <= '0;
                row_pos    <= '0;
                col_pos    <= VC_W'(1);
                graph_open <= (vcount != VC_W'(1));
              end else begin
                graph_open <= 1'b0;
              end
            end else if (graph_open) begin
              six      <= BITS_PER_CHAR'(char_in.char_code - HDR_OFFSET);
              data_idx <= '0;
            end
          end
        end
        ST_DECODE: begin
          if (set_edge) begin
            adj[ii][jj] <= 1'b1;
            adj[jj][ii] <= 1'b1;
            deg[ii]     <= deg[ii] + VC_W'(1);
            deg[jj]     <= deg[jj] + VC_W'(1);
            edges       <= edges + CUT_W'(1);
          end
          row_pos  <= row_n;
          col_pos  <= col_n;
          six      <= six << 1;
          data_idx <= data_idx + 3'd1;
          if (graph_full) begin
            graph_open <= 1'b0;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_status <= STATUS_OK;
            out_edges  <= edges;
            out_cut    <= peak_cut;
            out_def    <= bip[CUT_W-1:0];
            out_newrec <= new_rec;
            out_record <= record_next;
            out_ties   <= ties_next;
            out_graphs <= graphs_next;
            record     <= record_next;
            ties       <= ties_next;
            graphs     <= graphs_next;
          end
        end
        ST_ERROR: begin
          if (out_free) begin
            out_status <= STATUS_MISMATCH;
            out_edges  <= '0;
            out_cut    <= '0;
            out_def    <= '0;
            out_newrec <= 1'b0;
            out_record <= record;
            out_ties   <= ties;
            out_graphs <= graphs;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign result_out.valid             = out_valid;
  assign result_out.status            = out_status;
  assign result_out.edge_count        = out_edges;
  assign result_out.max_cut           = out_cut;
  assign result_out.deficiency        = out_def;
  assign result_out.new_record        = out_newrec;
  assign result_out.record_deficiency = out_record;
  assign result_out.record_ties       = out_ties;
  assign result_out.graphs_seen       = out_graphs;

  // record only grows
  `ASSERT_IMPLIES(a_record_monotonic, clk, rst, 1'b1, record >= $past(record))
  // once a record exists at least one graph holds it
  `ASSERT_IMPLIES(a_record_has_ties, clk, rst, !record[REC_W-1], ties != '0)
  // no character is taken while the cut stepper still has work in flight
  `ASSERT_IMPLIES(a_ready_idle_unit, clk, rst, char_in.ready, !stat.pending)

endmodule
`default_nettype wire
